// ----- rtl/go_back_n_sender_window_defines.svh -----
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GBN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbn check failed");

// next-cycle implication, disabled while reset is low
`define GBN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbn check failed");

`endif

// ----- rtl/gbn_pkg.sv -----
package gbn_pkg;

    typedef logic [1:0] op_t;
    localparam op_t OP_SEND = 2'd0;
    localparam op_t OP_ACK  = 2'd1;
    localparam op_t OP_TICK = 2'd2;
    localparam op_t OP_NONE = 2'd3;

    typedef logic [2:0] event_t;
    localparam event_t EV_SENT    = 3'd0;
    localparam event_t EV_REFUSED = 3'd1;
    localparam event_t EV_ACK_OK  = 3'd2;
    localparam event_t EV_ACK_IGN = 3'd3;
    localparam event_t EV_RESENT  = 3'd4;

    localparam logic REG_WINDOW  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam int WIN_W       = 5;
    localparam int TIMEOUT_W   = 20;
    localparam int CFG_W       = 20;
    localparam int SEQ_OUT_W   = 7;
    localparam int SLOT_OUT_W  = 4;
    localparam int TIME_W      = 32;
    localparam int WINDOW_RESET = 10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd100000;

    typedef struct packed {
        logic   capture;
        logic   time_tick;
        logic   walk_start;
        logic   walk_step;
        logic   do_send;
        logic   ack_release;
        logic   stamp;
        logic   diff_load;
        logic   emit;
        logic   last;
        event_t ev;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic walk_end;
        logic match;
        logic timeout;
        logic resend_last;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/gbn_datapath.sv -----
module gbn_datapath #(
    parameter int MAX_SLOTS        = 16,
    parameter int SEQUENCE_MODULUS = 127
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [gbn_pkg::CFG_W-1:0]         cfg_data,
    input  logic [gbn_pkg::SEQ_OUT_W-1:0]     ack_sequence,
    input  logic                              out_stall,
    input  gbn_pkg::cmd_t                     cmd,
    output gbn_pkg::status_t                  st,
    output logic                              out_valid,
    output logic [2:0]                        event_res,
    output logic [gbn_pkg::SEQ_OUT_W-1:0]     sequence_res,
    output logic [gbn_pkg::SLOT_OUT_W-1:0]    slot,
    output logic [gbn_pkg::SLOT_OUT_W-1:0]    released_count,
    output logic                              last
);

    localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LW = PW + 1;
    localparam int SW = (SEQUENCE_MODULUS > 1) ? $clog2(SEQUENCE_MODULUS) : 1;
    localparam int TW = gbn_pkg::TIME_W;
    localparam int RESET_LEN =
        (gbn_pkg::WINDOW_RESET > MAX_SLOTS) ? MAX_SLOTS : gbn_pkg::WINDOW_RESET;

    logic [SW-1:0] seq_mem [MAX_SLOTS];
    logic [TW-1:0] time_mem [MAX_SLOTS];

    logic [LW-1:0] ring_len_reg, ring_len_next;
    logic [gbn_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [PW-1:0] oldest_reg, oldest_next;
    logic [PW-1:0] next_ptr_reg, next_ptr_next;
    logic [SW-1:0] next_seq_reg, next_seq_next;
    logic [TW-1:0] time_reg, time_next;
    logic [PW-1:0] walk_reg, walk_next;
    logic [LW-1:0] count_reg, count_next;
    logic [gbn_pkg::SEQ_OUT_W-1:0] ack_reg;
    logic [TW-1:0] diff_reg;
    logic [SW-1:0] rd_seq_reg;
    logic [TW-1:0] rd_time_reg;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    ev_reg;
    logic [gbn_pkg::SEQ_OUT_W-1:0]  seq_out_reg;
    logic [gbn_pkg::SLOT_OUT_W-1:0] slot_out_reg;
    logic [gbn_pkg::SLOT_OUT_W-1:0] rel_out_reg;
    logic          last_reg;

    logic [gbn_pkg::WIN_W-1:0] win;
    logic [LW-1:0] len_wr;
    logic [PW-1:0] next_after_next, next_after_walk;
    logic [SW:0]   seq_inc;
    logic          out_free;

    function automatic logic [PW-1:0] ring_step(input logic [PW-1:0] p,
                                                input logic [LW-1:0] len);
        logic [LW-1:0] inc;
        inc = {1'b0, p} + 1'b1;
        if (inc == len)
            ring_step = '0;
        else
            ring_step = inc[PW-1:0];
    endfunction

    assign win = cfg_data[gbn_pkg::WIN_W-1:0];

    always_comb
    begin
        if (win < 5'd2)
            len_wr = LW'(2);
        else if (32'(win) > 32'(MAX_SLOTS))
            len_wr = LW'(MAX_SLOTS);
        else
            len_wr = LW'(win);
    end

    assign next_after_next = ring_step(next_ptr_reg, ring_len_reg);
    assign next_after_walk = ring_step(walk_reg, ring_len_reg);
    assign seq_inc         = {1'b0, next_seq_reg} + 1'b1;
    assign out_free        = !out_valid_reg || !out_stall;

    assign st.full        = (next_after_next == oldest_reg);
    assign st.empty       = (oldest_reg == next_ptr_reg);
    assign st.walk_end    = (walk_reg == next_ptr_reg);
    assign st.match       = (32'(rd_seq_reg) == 32'(ack_reg));
    assign st.timeout     = (diff_reg > {{(TW - gbn_pkg::TIMEOUT_W){1'b0}}, timeout_reg});
    assign st.resend_last = (next_after_walk == next_ptr_reg);
    assign st.out_free    = out_free;

    always_comb
    begin
        ring_len_next = ring_len_reg;
        timeout_next  = timeout_reg;
        oldest_next   = oldest_reg;
        next_ptr_next = next_ptr_reg;
        next_seq_next = next_seq_reg;
        time_next     = time_reg;

        if (cmd.time_tick)
            time_next = time_reg + 1'b1;
        if (cmd.do_send)
        begin
            next_ptr_next = next_after_next;
            if (seq_inc == (SW+1)'(SEQUENCE_MODULUS))
                next_seq_next = '0;
            else
                next_seq_next = seq_inc[SW-1:0];
        end
        if (cmd.ack_release)
            oldest_next = next_after_walk;

        if (cfg_write)
        begin
            if (cfg_index == gbn_pkg::REG_WINDOW)
            begin
                ring_len_next = len_wr;
                oldest_next   = '0;
                next_ptr_next = '0;
            end
            else
                timeout_next = cfg_data[gbn_pkg::TIMEOUT_W-1:0];
        end
    end

    always_comb
    begin
        walk_next  = walk_reg;
        count_next = count_reg;
        if (cmd.walk_start)
        begin
            walk_next  = oldest_reg;
            count_next = '0;
        end
        else if (cmd.walk_step)
        begin
            walk_next  = next_after_walk;
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = cmd.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_len_reg  <= LW'(RESET_LEN);
            timeout_reg   <= gbn_pkg::TIMEOUT_RESET;
            oldest_reg    <= '0;
            next_ptr_reg  <= '0;
            next_seq_reg  <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ring_len_reg  <= ring_len_next;
            timeout_reg   <= timeout_next;
            oldest_reg    <= oldest_next;
            next_ptr_reg  <= next_ptr_next;
            next_seq_reg  <= next_seq_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg  <= walk_next;
        count_reg <= count_next;
        if (cmd.capture)
            ack_reg <= ack_sequence;
        if (cmd.diff_load)
            diff_reg <= time_reg - rd_time_reg;
    end

    // slot stores, read address follows the next value of the walk pointer
    always_ff @(posedge clk)
    begin
        if (cmd.do_send)
        begin
            seq_mem[next_ptr_reg]  <= next_seq_reg;
            time_mem[next_ptr_reg] <= time_reg;
        end
        else if (cmd.stamp)
            time_mem[walk_reg] <= time_reg;
    end

    always_ff @(posedge clk)
    begin
        rd_seq_reg  <= seq_mem[walk_next];
        rd_time_reg <= time_mem[walk_next];
    end

    always_ff @(posedge clk)
    begin
        if (out_free && cmd.emit)
        begin
            ev_reg   <= cmd.ev;
            last_reg <= cmd.last;
            case (cmd.ev)
                gbn_pkg::EV_SENT:
                begin
                    seq_out_reg  <= gbn_pkg::SEQ_OUT_W'(next_seq_reg);
                    slot_out_reg <= gbn_pkg::SLOT_OUT_W'(next_ptr_reg);
                    rel_out_reg  <= '0;
                end
                gbn_pkg::EV_ACK_OK:
                begin
                    seq_out_reg  <= ack_reg;
                    slot_out_reg <= gbn_pkg::SLOT_OUT_W'(walk_reg);
                    rel_out_reg  <= gbn_pkg::SLOT_OUT_W'(count_reg + 1'b1);
                end
                gbn_pkg::EV_ACK_IGN:
                begin
                    seq_out_reg  <= ack_reg;
                    slot_out_reg <= '0;
                    rel_out_reg  <= '0;
                end
                gbn_pkg::EV_RESENT:
                begin
                    seq_out_reg  <= gbn_pkg::SEQ_OUT_W'(rd_seq_reg);
                    slot_out_reg <= gbn_pkg::SLOT_OUT_W'(walk_reg);
                    rel_out_reg  <= '0;
                end
                default:
                begin
                    seq_out_reg  <= '0;
                    slot_out_reg <= '0;
                    rel_out_reg  <= '0;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = ev_reg;
    assign sequence_res   = seq_out_reg;
    assign slot           = slot_out_reg;
    assign released_count = rel_out_reg;
    assign last           = last_reg;

endmodule

// ----- rtl/gbn_controller.sv -----
module gbn_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        operation,
    input  gbn_pkg::status_t  st,
    output logic              in_stall,
    output gbn_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEND   = 3'd1;
    localparam logic [2:0] ST_ACK    = 3'd2;
    localparam logic [2:0] ST_TICK   = 3'd3;
    localparam logic [2:0] ST_TCMP   = 3'd4;
    localparam logic [2:0] ST_RESEND = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ev     = gbn_pkg::EV_SENT;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture    = 1'b1;
                    cmd.walk_start = 1'b1;
                    case (operation)
                        gbn_pkg::OP_SEND: state_next = ST_SEND;
                        gbn_pkg::OP_ACK:  state_next = ST_ACK;
                        gbn_pkg::OP_TICK:
                        begin
                            cmd.time_tick = 1'b1;
                            state_next    = ST_TICK;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEND:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    if (st.full)
                        cmd.ev = gbn_pkg::EV_REFUSED;
                    else
                    begin
                        cmd.ev      = gbn_pkg::EV_SENT;
                        cmd.do_send = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ACK:
            begin
                // one slot compared per cycle, oldest first
                if (st.walk_end || st.match)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        if (st.walk_end)
                            cmd.ev = gbn_pkg::EV_ACK_IGN;
                        else
                        begin
                            cmd.ev          = gbn_pkg::EV_ACK_OK;
                            cmd.ack_release = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                    cmd.walk_step = 1'b1;
            end
            ST_TICK:
            begin
                if (st.empty)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.diff_load = 1'b1;
                    state_next    = ST_TCMP;
                end
            end
            ST_TCMP:
            begin
                if (st.timeout)
                    state_next = ST_RESEND;
                else
                    state_next = ST_IDLE;
            end
            ST_RESEND:
            begin
                if (st.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.ev    = gbn_pkg::EV_RESENT;
                    cmd.stamp = 1'b1;
                    cmd.last  = st.resend_last;
                    if (st.resend_last)
                        state_next = ST_IDLE;
                    else
                        cmd.walk_step = 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/go_back_n_sender_window.sv -----
// Go-back-N ARQ sender window. A ring of window_size slots (clamped to 2..MAX_SLOTS) tracks
// outstanding packets with one slot kept free. Operation 0 sends (or refuses when full),
// operation 1 searches an acknowledgement from the oldest slot and releases up to the match,
// operation 2 advances time by one tick and, on timeout of the oldest slot, resends every
// outstanding slot in order with one result per slot. One item is handled at a time: the
// input stalls until the item is done, and a stalled output holds it longer. The slot walk
// reads one slot store entry per cycle unless a stalled output holds a resend. Writing
// window_size empties the ring; the user must write configuration only while the block is
// idle, the block itself does not enforce this.
module go_back_n_sender_window #(
    parameter int MAX_SLOTS        = 16,
    parameter int SEQUENCE_MODULUS = 127
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [6:0]  ack_sequence,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [6:0]  sequence_res,
    output logic [3:0]  slot,
    output logic [3:0]  released_count,
    output logic        last
);

    gbn_pkg::cmd_t    cmd;
    gbn_pkg::status_t st;

    gbn_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .st        (st),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    gbn_datapath #(
        .MAX_SLOTS        (MAX_SLOTS),
        .SEQUENCE_MODULUS (SEQUENCE_MODULUS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ack_sequence   (ack_sequence),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .event_res      (event_res),
        .sequence_res   (sequence_res),
        .slot           (slot),
        .released_count (released_count),
        .last           (last)
    );

endmodule

// ----- rtl/gbn_checker.sv -----
`include "go_back_n_sender_window_defines.svh"

module gbn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] operation,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] event_res,
    input logic [6:0] sequence_res,
    input logic [3:0] slot,
    input logic [3:0] released_count,
    input logic       last
);

    // a stalled result holds
    `GBN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(event_res) && $stable(sequence_res) && $stable(slot) && $stable(last))

    // only a resend can leave more results to come
    `GBN_ASSERT_NOW(a_single_last, clk, rst_n, out_valid && (event_res != gbn_pkg::EV_RESENT), last)

    // a release count shows up exactly on an accepted ack
    `GBN_ASSERT_NOW(a_release, clk, rst_n, out_valid, (event_res == gbn_pkg::EV_ACK_OK) == (released_count != 4'd0))

    // a real operation makes the input side busy on the following cycle
    `GBN_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall && (operation != gbn_pkg::OP_NONE), in_stall)

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_res      (event_res),
    .sequence_res   (sequence_res),
    .slot           (slot),
    .released_count (released_count),
    .last           (last)
);

// ----- test/gbn_window_checker.sv -----
module gbn_window_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [6:0]  ack_sequence,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  event_res,
    input  logic [6:0]  sequence_res,
    input  logic [3:0]  slot,
    input  logic [3:0]  released_count,
    input  logic        last,
    output int          failures,
    output int          pending,
    output int          compared,
    output logic [6:0]  next_seq_hint
);

    localparam int SLOTS   = 16;
    localparam int SEQ_MOD = 127;

    typedef struct packed {
        gbn_pkg::event_t ev;
        logic [6:0]      seq;
        logic [3:0]      slot;
        logic [3:0]      released;
        logic            last;
    } window_event_t;

    window_event_t awaited[$];

    logic [gbn_pkg::WIN_W-1:0]     window_reg;
    logic [gbn_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [6:0]                    seq_of_slot [SLOTS];
    logic [gbn_pkg::TIME_W-1:0]    stamp_of_slot [SLOTS];
    int                            oldest;
    int                            newest;
    logic [6:0]                    seq_next;
    logic [gbn_pkg::TIME_W-1:0]    now;
    int                            fail_count = 0;
    int                            compare_count = 0;

    function automatic int ring_len();
        int w;
        w = int'(window_reg);
        if (w < 2)
            w = 2;
        if (w > SLOTS)
            w = SLOTS;
        return w;
    endfunction

    function automatic int ring_next(input int p);
        return (p + 1) % ring_len();
    endfunction

    task automatic await_event(input gbn_pkg::event_t ev, input logic [6:0] s, input int sl,
                               input int rel, input logic l);
        window_event_t e;
        e.ev       = ev;
        e.seq      = s;
        e.slot     = sl[3:0];
        e.released = rel[3:0];
        e.last     = l;
        awaited.push_back(e);
    endtask

    task automatic window_step(input gbn_pkg::op_t op, input logic [6:0] ack);
        int          p;
        int          count;
        int          n;
        bit          found;
        logic [31:0] waited;
        case (op)
            gbn_pkg::OP_SEND:
            begin
                if (ring_next(newest) == oldest)
                    await_event(gbn_pkg::EV_REFUSED, 7'd0, 0, 0, 1'b1);
                else
                begin
                    seq_of_slot[newest]   = seq_next;
                    stamp_of_slot[newest] = now;
                    await_event(gbn_pkg::EV_SENT, seq_next, newest, 0, 1'b1);
                    newest   = ring_next(newest);
                    seq_next = (int'(seq_next) == SEQ_MOD - 1) ? 7'd0 : seq_next + 7'd1;
                end
            end
            gbn_pkg::OP_ACK:
            begin
                p     = oldest;
                count = 0;
                found = 0;
                // search from the oldest outstanding slot toward the newest
                while (p != newest && count < SLOTS && !found)
                begin
                    count++;
                    if (seq_of_slot[p] == ack)
                    begin
                        found = 1;
                        await_event(gbn_pkg::EV_ACK_OK, ack, p, count, 1'b1);
                        oldest = ring_next(p);
                    end
                    else
                        p = ring_next(p);
                end
                if (!found)
                    await_event(gbn_pkg::EV_ACK_IGN, ack, 0, 0, 1'b1);
            end
            gbn_pkg::OP_TICK:
            begin
                now = now + 32'd1;
                if (oldest != newest)
                begin
                    waited = now - stamp_of_slot[oldest];
                    if (waited > 32'(timeout_reg))
                    begin
                        p = oldest;
                        n = 0;
                        while (p != newest && n < SLOTS)
                        begin
                            stamp_of_slot[p] = now;
                            await_event(gbn_pkg::EV_RESENT, seq_of_slot[p], p, 0,
                                        ring_next(p) == newest);
                            n++;
                            p = ring_next(p);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result();
        window_event_t want;
        if (awaited.size() == 0)
        begin
            $error("unexpected result: event_res %0d sequence_res %0d slot %0d",
                   event_res, sequence_res, slot);
            fail_count++;
        end
        else
        begin
            want = awaited.pop_front();
            compare_count++;
            if (event_res !== want.ev)
            begin
                $error("event_res: expected %0d, got %0d", want.ev, event_res);
                fail_count++;
            end
            if (sequence_res !== want.seq)
            begin
                $error("sequence_res: expected %0d, got %0d", want.seq, sequence_res);
                fail_count++;
            end
            if (slot !== want.slot)
            begin
                $error("slot: expected %0d, got %0d", want.slot, slot);
                fail_count++;
            end
            if (released_count !== want.released)
            begin
                $error("released_count: expected %0d, got %0d", want.released, released_count);
                fail_count++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, last);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            awaited.delete();
            window_reg  = gbn_pkg::WIN_W'(gbn_pkg::WINDOW_RESET);
            timeout_reg = gbn_pkg::TIMEOUT_RESET;
            oldest      = 0;
            newest      = 0;
            seq_next    = 7'd0;
            now         = '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == gbn_pkg::REG_WINDOW)
                begin
                    // a new window size empties the ring
                    window_reg = cfg_data[gbn_pkg::WIN_W-1:0];
                    oldest     = 0;
                    newest     = 0;
                end
                else
                    timeout_reg = cfg_data[gbn_pkg::TIMEOUT_W-1:0];
            end
            if (in_valid && !in_stall)
                window_step(operation, ack_sequence);
            if (out_valid && !out_stall)
                check_result();
        end
        pending       <= awaited.size();
        next_seq_hint <= seq_next;
        failures      <= fail_count;
        compared      <= compare_count;
    end

endmodule

// ----- test/tb_go_back_n_sender_window.sv -----
module tb_go_back_n_sender_window;

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 16;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [19:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [6:0]  ack_sequence;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_res;
    logic [6:0]  sequence_res;
    logic [3:0]  slot;
    logic [3:0]  released_count;
    logic        last;

    int          failures;
    int          pending;
    int          compared;
    logic [6:0]  next_seq_hint;

    logic        quiet;
    logic        hold_off;
    int          items_done = 0;
    int          settings_done = 0;
    int          idle_cycles = 0;

    logic [4:0]  win_plan [N_PHASES] = '{5'd31, 5'd16, 5'd2, 5'd1, 5'd10, 5'd16, 5'd7, 5'd16};
    logic [19:0] tmo_plan [N_PHASES] = '{20'd1, 20'd3, 20'hFFFFF, 20'd5, 20'd6, 20'd1,
                                         20'd12, 20'd4};

    always #5 clk = ~clk;

    go_back_n_sender_window dut (.*);

    gbn_window_checker checker_i (.*);

    // ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_go_back_n_sender_window failed");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        bit hold_taken;
        hold_taken = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_taken)
            begin
                hold_taken = 1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic drive_item(input gbn_pkg::op_t op, input logic [6:0] ack);
        in_valid     <= 1'b1;
        operation    <= op;
        ack_sequence <= ack;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_done++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // waits until every result is out, then writes both registers
    task automatic set_config(input logic [4:0] win, input logic [19:0] tmo);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= gbn_pkg::REG_WINDOW;
        cfg_data  <= 20'(win);
        @(posedge clk);
        cfg_index <= gbn_pkg::REG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_done++;
    endtask

    task automatic random_item(output bit counts);
        int pick;
        int back;
        pick   = $urandom_range(0, 99);
        counts = 1;
        if (pick < 40)
            drive_item(gbn_pkg::OP_SEND, 7'($urandom));
        else if (pick < 68)
        begin
            // aim at a recently sent sequence number
            back = int'(next_seq_hint) - 1 - int'($urandom_range(0, 5));
            if (back < 0)
                back += 127;
            drive_item(gbn_pkg::OP_ACK, 7'(back));
        end
        else if (pick < 74)
            drive_item(gbn_pkg::OP_ACK, 7'($urandom));
        else if (pick < 96)
            drive_item(gbn_pkg::OP_TICK, 7'($urandom));
        else
        begin
            drive_item(gbn_pkg::OP_NONE, 7'($urandom));
            counts = 0;
        end
    endtask

    initial
    begin
        bit counts;
        int phase_items;
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= gbn_pkg::REG_WINDOW;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        operation    <= gbn_pkg::OP_NONE;
        ack_sequence <= '0;
        quiet        <= 1'b0;
        hold_off     <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // four-slot ring: ignored op, empty ring, full ring, partial release, timeout
        set_config(5'd4, 20'd2);
        drive_item(gbn_pkg::OP_NONE, 7'h55);
        drive_item(gbn_pkg::OP_TICK, 7'h2A);
        drive_item(gbn_pkg::OP_ACK, 7'h7F);
        repeat (4) drive_item(gbn_pkg::OP_SEND, 7'd0);
        drive_item(gbn_pkg::OP_ACK, 7'd1);
        drive_item(gbn_pkg::OP_ACK, 7'd0);
        repeat (4) drive_item(gbn_pkg::OP_TICK, 7'd0);
        drive_item(gbn_pkg::OP_ACK, 7'd2);
        drive_item(gbn_pkg::OP_SEND, 7'd0);
        drive_item(gbn_pkg::OP_ACK, 7'd3);

        // window below range acts as two slots, shortest timeout
        set_config(5'd0, 20'd1);
        drive_item(gbn_pkg::OP_SEND, 7'd0);
        drive_item(gbn_pkg::OP_SEND, 7'd0);
        drive_item(gbn_pkg::OP_TICK, 7'd0);
        drive_item(gbn_pkg::OP_TICK, 7'd0);
        drive_item(gbn_pkg::OP_ACK, 7'd4);
        drive_item(gbn_pkg::OP_ACK, 7'd0);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_config(win_plan[ph], tmo_plan[ph]);
            if (ph == 1)
                hold_off <= 1'b1;
            if (ph == N_PHASES - 1)
                quiet <= 1'b1;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                random_item(counts);
                if (counts)
                    phase_items++;
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);

        $display("covered %0d input items over %0d window/timeout settings, %0d results compared",
                 items_done, settings_done, compared);
        $display("settings spanned clamped window sizes at both ends and timeouts of 1 to 1048575");
        if (failures == 0)
            $display("tb_go_back_n_sender_window passed");
        else
            $display("tb_go_back_n_sender_window failed");
        $finish;
    end

endmodule
